// File: src/quadrature_pair_decoder_autolock_assert.svh
// assertion macros for the quadrature pair decoder
`ifndef QUADRATURE_PAIR_DECODER_AUTOLOCK_ASSERT_SVH
`define QUADRATURE_PAIR_DECODER_AUTOLOCK_ASSERT_SVH

// same-cycle implication, checked on clk and disabled in reset
`define QPDAL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on clk and disabled in reset
`define QPDAL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/qpdal_pkg.sv
// types, constants and tables shared by the quadrature pair decoder
package qpdal_pkg;

  localparam int NUM_PAIRS  = 3;
  localparam int TABLE_SIZE = 3;

  localparam logic [1:0] NO_LOCK    = 2'd3;
  localparam logic [2:0] THR_RESET  = 3'd2;
  localparam logic [2:0] THR_MIN    = 3'd1;

  localparam logic signed [1:0] STEP_NONE = 2'sb00;
  localparam logic signed [1:0] STEP_POS  = 2'sb01;
  localparam logic signed [1:0] STEP_NEG  = 2'sb11;

  // line indexes forming each candidate pair, state is {line a, line b}
  localparam logic [1:0] LINE_A [TABLE_SIZE] = '{2'd0, 2'd2, 2'd2};
  localparam logic [1:0] LINE_B [TABLE_SIZE] = '{2'd1, 2'd1, 2'd0};

  // indexed by {previous state, current state}
  localparam logic signed [1:0] QUAD_DELTA [16] = '{
    2'sb00, 2'sb11, 2'sb01, 2'sb00,
    2'sb01, 2'sb00, 2'sb00, 2'sb11,
    2'sb11, 2'sb00, 2'sb00, 2'sb01,
    2'sb00, 2'sb01, 2'sb11, 2'sb00
  };

  typedef struct packed {
    logic line_zero;
    logic line_one;
    logic line_two;
  } in_item_t;

  typedef struct packed {
    logic signed [1:0] step;
    logic [1:0]        locked_pair;
  } out_item_t;

  typedef struct packed {
    logic              changed;
    logic              nonzero;
    logic              hit;
    logic signed [3:0] accum_nxt;
    logic signed [1:0] step;
  } pair_res_t;

endpackage

// File: src/quadrature_pair_decoder_autolock.sv
// One item per clock in, one result item per clock out while out_stall is low;
// each item passes the input register, then the result register. The per-pair
// update of state, accumulator and lock is combinational logic between the two
// registers and sets the rate. The first item after reset only records each
// pair's state and reports no step. The first pair to reach the threshold
// locks; from then on only that pair is tracked. step_threshold of zero acts
// as one and should be written only while no item is in flight.
module quadrature_pair_decoder_autolock (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  qpdal_pkg::in_item_t   in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output qpdal_pkg::out_item_t  out_item,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [2:0]            cfg_step_threshold
);
  import qpdal_pkg::*;

  logic              s1_valid_r;
  in_item_t          in_item_r;
  logic              out_valid_r;
  out_item_t         out_item_r;
  out_item_t         out_item_nxt;
  logic [2:0]        thr_r;
  logic [2:0]        thr_eff;
  logic              primed_r;
  logic [1:0]        lock_r;
  logic [1:0]        lock_nxt;
  logic [1:0]        prev_r   [NUM_PAIRS];
  logic [1:0]        prev_nxt [NUM_PAIRS];
  logic signed [3:0] accum_r   [NUM_PAIRS];
  logic signed [3:0] accum_nxt [NUM_PAIRS];
  logic [1:0]        cur_state [NUM_PAIRS];
  pair_res_t         res       [NUM_PAIRS];
  logic [2:0]        lines;
  logic              s1_go;
  logic              in_take;
  logic              fire;

  assign s1_go     = !out_valid_r || !out_stall;
  assign in_stall  = s1_valid_r && !s1_go;
  assign in_take   = in_valid && !in_stall;
  assign fire      = s1_valid_r && s1_go;
  assign cfg_ready = !s1_valid_r;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  assign lines   = {in_item_r.line_two, in_item_r.line_one, in_item_r.line_zero};
  assign thr_eff = (thr_r == 3'd0) ? THR_MIN : thr_r;

  for (genvar g = 0; g < NUM_PAIRS; g++) begin : g_pair
    assign cur_state[g] = {lines[LINE_A[g]], lines[LINE_B[g]]};

    qpdal_pair_eval u_eval (
      .prev_state (prev_r[g]),
      .cur_state  (cur_state[g]),
      .accum      (accum_r[g]),
      .threshold  (thr_eff),
      .res        (res[g])
    );
  end

  // pairs in index order; a pair that steps locks and masks later pairs
  always_comb begin
    logic emitted;
    logic en;
    emitted      = 1'b0;
    lock_nxt     = lock_r;
    out_item_nxt = '{step: STEP_NONE, locked_pair: lock_r};
    for (int i = 0; i < NUM_PAIRS; i++) begin
      prev_nxt[i]  = prev_r[i];
      accum_nxt[i] = accum_r[i];
      en = primed_r && !emitted && res[i].changed &&
           ((lock_r == NO_LOCK) || (lock_r == 2'(i)));
      if (!primed_r || en) begin
        prev_nxt[i] = cur_state[i];
      end
      if (en && res[i].nonzero) begin
        accum_nxt[i] = res[i].accum_nxt;
      end
      if (en && res[i].hit) begin
        emitted           = 1'b1;
        out_item_nxt.step = res[i].step;
        if (lock_r == NO_LOCK) begin
          lock_nxt = 2'(i);
        end
      end
    end
    out_item_nxt.locked_pair = lock_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      thr_r       <= THR_RESET;
      primed_r    <= 1'b0;
      lock_r      <= NO_LOCK;
      for (int i = 0; i < NUM_PAIRS; i++) begin
        accum_r[i] <= 4'sd0;
      end
    end else begin
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (s1_go) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_go) begin
        out_valid_r <= s1_valid_r;
      end
      if (cfg_valid && cfg_ready) begin
        thr_r <= cfg_step_threshold;
      end
      if (fire) begin
        primed_r <= 1'b1;
        lock_r   <= lock_nxt;
        for (int i = 0; i < NUM_PAIRS; i++) begin
          accum_r[i] <= accum_nxt[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r <= in_item;
    end
    if (fire) begin
      out_item_r <= out_item_nxt;
      for (int i = 0; i < NUM_PAIRS; i++) begin
        prev_r[i] <= prev_nxt[i];
      end
    end
  end

`include "quadrature_pair_decoder_autolock_assert.svh"

  `QPDAL_ASSERT_NEXT(a_lock_holds, lock_r != NO_LOCK, lock_r == $past(lock_r), "lock changed after it was taken")
  `QPDAL_ASSERT_NOW(a_step_locked, out_valid_r && (out_item_r.step != STEP_NONE), out_item_r.locked_pair != NO_LOCK, "step reported with no locked pair")
  `QPDAL_ASSERT_NOW(a_unprimed_unlocked, !primed_r, lock_r == NO_LOCK, "lock taken before the priming item")
  `QPDAL_ASSERT_NEXT(a_result_follows, fire, out_valid_r, "processed item left no result")

endmodule

// File: src/qpdal_pair_eval.sv
// transition lookup, accumulate and threshold check for one line pair
module qpdal_pair_eval (
  input  logic [1:0]            prev_state,
  input  logic [1:0]            cur_state,
  input  logic signed [3:0]     accum,
  input  logic [2:0]            threshold,
  output qpdal_pkg::pair_res_t  res
);
  import qpdal_pkg::*;

  logic signed [1:0] delta;
  logic signed [4:0] sum;
  logic signed [4:0] thr_s;

  assign delta = QUAD_DELTA[{prev_state, cur_state}];
  assign sum   = 5'(accum) + 5'(delta);
  assign thr_s = signed'({2'b00, threshold});

  always_comb begin
    res.changed   = (cur_state != prev_state);
    res.nonzero   = (delta != STEP_NONE);
    res.hit       = res.changed && res.nonzero && ((sum >= thr_s) || (sum <= -thr_s));
    res.accum_nxt = res.hit ? 4'sd0 : sum[3:0];
    res.step      = (sum > 5'sd0) ? STEP_POS : STEP_NEG;
  end

endmodule

// File: bench/tb_top.sv
// self-checking bench for the quadrature pair decoder with automatic pair lock
`timescale 1ns / 100ps

module tb_top;
  import qpdal_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASE_ITEMS  = 117;
  localparam int LINE_HI [3]  = '{0, 2, 2};
  localparam int LINE_LO [3]  = '{1, 1, 0};

  logic       clk;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  in_item_t   in_item = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_item_t  out_item;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [2:0] cfg_step_threshold = 3'd0;

  // stimulus generator state
  logic [2:0] cur_lines = 3'b000;
  logic       dir_up = 1'b1;
  int         cycle_count = 0;
  int         stall_mode = 0;
  int         stall_left = 0;

  // one quadrature step of a 2-bit state; up runs 0 -> 2 -> 3 -> 1 -> 0
  function automatic logic [1:0] gray_next(logic [1:0] s, logic up);
    case (s)
      2'd0: gray_next = up ? 2'd2 : 2'd1;
      2'd1: gray_next = up ? 2'd0 : 2'd3;
      2'd2: gray_next = up ? 2'd3 : 2'd0;
      default: gray_next = up ? 2'd1 : 2'd2;
    endcase
  endfunction

  class detent_tracker;
    logic [2:0]  threshold = THR_RESET;
    bit          primed = 1'b0;
    logic [1:0]  prev_state [3];
    int          accum [3] = '{0, 0, 0};
    logic [1:0]  lock_pair = NO_LOCK;
    out_item_t   pending_steps [$];
    int          failures = 0;
    int          result_count = 0;

    function void flag(string msg);
      failures++;
      if (failures <= 10) $display("%s", msg);
    endfunction

    function void load_threshold(logic [2:0] v);
      threshold = v;
    endfunction

    function int transition_delta(logic [1:0] from, logic [1:0] to);
      if (to == gray_next(from, 1'b1)) return 1;
      if (to == gray_next(from, 1'b0)) return -1;
      return 0;
    endfunction

    function void take_sample(in_item_t s);
      logic [2:0]        lines;
      logic [1:0]        cur;
      logic signed [1:0] step;
      int                thr;
      int                d;
      int                acc;
      out_item_t         want;
      lines = {s.line_two, s.line_one, s.line_zero};
      thr = (threshold == 3'd0) ? 1 : int'(threshold);
      step = STEP_NONE;
      for (int i = 0; i < 3; i++) begin
        cur = {lines[LINE_HI[i]], lines[LINE_LO[i]]};
        if (!primed) begin
          prev_state[i] = cur;
          continue;
        end
        if (lock_pair != NO_LOCK && lock_pair != i) continue;
        if (cur == prev_state[i]) continue;
        d = transition_delta(prev_state[i], cur);
        prev_state[i] = cur;
        if (d == 0) continue;
        acc = accum[i] + d;
        if (acc >= thr || acc <= -thr) begin
          step = (acc > 0) ? STEP_POS : STEP_NEG;
          acc = 0;
          if (lock_pair == NO_LOCK) lock_pair = i[1:0];
        end
        accum[i] = acc;
      end
      primed = 1'b1;
      want.step = step;
      want.locked_pair = lock_pair;
      pending_steps.push_back(want);
    endfunction

    function void compare_step(out_item_t got);
      out_item_t want;
      result_count++;
      if (pending_steps.size() == 0) begin
        flag($sformatf("result %0d: no item pending, got step %0d pair %0d",
                       result_count, got.step, got.locked_pair));
        return;
      end
      want = pending_steps.pop_front();
      if (got.step !== want.step)
        flag($sformatf("result %0d: step expected %0d actual %0d",
                       result_count, want.step, got.step));
      if (got.locked_pair !== want.locked_pair)
        flag($sformatf("result %0d: locked_pair expected %0d actual %0d",
                       result_count, want.locked_pair, got.locked_pair));
    endfunction
  endclass

  detent_tracker tracker;

  quadrature_pair_decoder_autolock dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_item            (in_item),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_item           (out_item),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_step_threshold (cfg_step_threshold)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // handshake monitor feeding the tracker
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) tracker.load_threshold(cfg_step_threshold);
      if (in_valid && !in_stall) tracker.take_sample(in_item);
      if (out_valid && !out_stall) tracker.compare_step(out_item);
    end
  end

  // receiver back-pressure, switching between patterns
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(16, 96);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= stall_left[2];
    endcase
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("quadrature_pair_decoder_autolock regression: fail");
      $finish;
    end
  end

  task automatic send_item(input logic [2:0] lines);
    in_item_t it;
    it.line_zero = lines[0];
    it.line_one  = lines[1];
    it.line_two  = lines[2];
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic write_threshold(input logic [2:0] v);
    cfg_valid          <= 1'b1;
    cfg_step_threshold <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // hold off until every expected result is back and the pipe is empty
  task automatic settle();
    while (tracker.pending_steps.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // next sample: mostly clean rotation of one pair, some jumps and noise
  task automatic next_lines(input int target);
    logic [1:0] s;
    int         pick;
    pick = $urandom_range(0, 99);
    s = {cur_lines[LINE_HI[target]], cur_lines[LINE_LO[target]]};
    if (pick < 78) begin
      if (pick >= 70) dir_up = ~dir_up;
      s = gray_next(s, dir_up);
    end else if (pick < 92) begin
      if (pick >= 85) s = ~s;
    end else begin
      cur_lines = 3'($urandom_range(0, 7));
      return;
    end
    cur_lines[LINE_HI[target]] = s[1];
    cur_lines[LINE_LO[target]] = s[0];
  endtask

  task automatic run_phase(input int n_items);
    int sent;
    int burst;
    int gap;
    int target;
    sent = 0;
    while (sent < n_items) begin
      burst = $urandom_range(1, 24);
      if (tracker.lock_pair == NO_LOCK || $urandom_range(0, 6) == 0)
        target = $urandom_range(0, 2);
      else
        target = int'(tracker.lock_pair);
      dir_up = 1'($urandom_range(0, 1));
      for (int k = 0; k < burst && sent < n_items; k++) begin
        next_lines(target);
        send_item(cur_lines);
        sent++;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0 && sent < n_items) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b0;
  endtask

  logic [2:0] directed_lines [18] = '{
    3'b000, 3'b000, 3'b001, 3'b011, 3'b111, 3'b110, 3'b100, 3'b101, 3'b010,
    3'b010, 3'b101, 3'b001, 3'b000, 3'b100, 3'b110, 3'b111, 3'b011, 3'b001
  };
  logic [2:0] thr_order [8];

  initial begin
    int         j;
    logic [2:0] t;
    tracker = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: priming, unchanged, double-bit jumps, every line level,
    // threshold above four so nothing locks yet
    write_threshold(3'd7);
    foreach (directed_lines[i]) send_item(directed_lines[i]);
    in_valid <= 1'b0;
    cur_lines = directed_lines[17];
    settle();

    // zero threshold acts as one; toggling line one moves pairs 0 and 1 together
    if ($urandom_range(0, 1) == 1) begin
      write_threshold(3'd0);
      cur_lines[1] = ~cur_lines[1];
      send_item(cur_lines);
      in_valid <= 1'b0;
      settle();
    end

    for (int i = 0; i < 8; i++) thr_order[i] = 3'(i);
    for (int i = 7; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = thr_order[i];
      thr_order[i] = thr_order[j];
      thr_order[j] = t;
    end

    foreach (thr_order[i]) begin
      write_threshold(thr_order[i]);
      run_phase(PHASE_ITEMS);
      settle();
    end

    repeat (8) @(posedge clk);
    if (tracker.pending_steps.size() != 0)
      tracker.flag($sformatf("%0d expected results never arrived",
                             tracker.pending_steps.size()));
    if (tracker.failures == 0)
      $display("quadrature_pair_decoder_autolock regression: pass");
    else
      $display("quadrature_pair_decoder_autolock regression: fail");
    $finish;
  end

endmodule
